>>> sv/elcsr_pkg.sv
// ----------------------------------------------------------------------------
// elcsr_pkg
// Shared types and constants of the edge list to CSR adjacency converter.
// ----------------------------------------------------------------------------
`default_nettype none

package elcsr_pkg;

	localparam int unsigned MaxVertices = 16;
	localparam int unsigned MaxEdges    = 48;
	localparam int unsigned VtxW        = $clog2(MaxVertices);
	localparam int unsigned CntW        = $clog2(MaxEdges + 1);
	localparam int unsigned PairW       = 2 * VtxW;
	localparam int unsigned PairDepth   = MaxVertices * MaxVertices;
	localparam int unsigned RemW        = $clog2(MaxVertices + MaxEdges + 1);

	localparam logic KindHeader   = 1'b0;
	localparam logic KindNeighbor = 1'b1;

	typedef struct packed {
		logic [31:0] source;
		logic [31:0] target;
		logic        last;
	} edge_t;

	typedef struct packed {
		logic            kind;
		logic [3:0]      vertex;
		logic [5:0]      degree;
		logic [3:0]      neighbor;
		logic            overflow;
		logic            last_item;
	} item_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_LOAD,
		ST_WAIT,
		ST_HDR,
		ST_RD,
		ST_LAT,
		ST_EM
	} state_t;

endpackage

`default_nettype wire

>>> sv/elcsr_if.sv
// ----------------------------------------------------------------------------
// elcsr channel interfaces
// Valid/ready channels for edge words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface elcsr_edge_if;
	logic                 valid;
	logic                 ready;
	elcsr_pkg::edge_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface elcsr_item_if;
	logic                 valid;
	logic                 ready;
	elcsr_pkg::item_t     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/elcsr_ram.sv
// ----------------------------------------------------------------------------
// elcsr_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module elcsr_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/edge_list_to_csr_adjacency.sv
// ----------------------------------------------------------------------------
// edge_list_to_csr_adjacency
// Collects directed edges and emits a row-sorted CSR adjacency listing.
// ----------------------------------------------------------------------------
// Edges arrive one word per cycle on the edges channel. Self-loops are
// dropped; out-of-range ids or a full edge budget drop the edge and set a
// sticky overflow bit. Each kept edge increments a per-(source, target)
// multiplicity count held in a 256 x 6 RAM with a registered read, through a
// read-modify-write pipe with forwarding; a new edge need not wait for a write.
// The word marked last closes the run: edges stops accepting, and the block
// walks rows 0..max id, giving a header word (vertex, degree) and then the
// neighbors of that row in ascending order, each target repeated by its
// multiplicity. A row with edges gives a header word, then walks its 16 target
// slots in order, reading then latching each, with one neighbor word per unit
// of count; an empty row gives only its header. The walk ends at the final
// word. Counts are zeroed as they are read, and degrees, max id and overflow
// are cleared after the final word.
// After reset a clearing pass over all 256 pairs zeroes the count RAM while edges
// is held not ready. A stalled items channel holds its word in the output
// register and the row walk waits; a new edge can be taken while the final
// word of the previous run is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_list_to_csr_adjacency (
	input  wire logic   clk,
	input  wire logic   arst_n,
	elcsr_edge_if.sink  edges,
	elcsr_item_if.source items
);

	localparam int unsigned VW = elcsr_pkg::VtxW;
	localparam int unsigned CW = elcsr_pkg::CntW;
	localparam int unsigned AW = elcsr_pkg::PairW;
	localparam int unsigned RW = elcsr_pkg::RemW;

	elcsr_pkg::state_t state_q, state_n;

	logic [VW-1:0] v_q, t_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [AW-1:0] clr_q;
	logic [CW-1:0] deg_q [elcsr_pkg::MaxVertices];
	logic [VW-1:0] max_q;
	logic [CW-1:0] ecnt_q;
	logic          ovf_q;

	logic          v_s1;
	logic [AW-1:0] addr_s1;
	logic          lw_v_q;
	logic [AW-1:0] lw_addr_q;
	logic [CW-1:0] lw_data_q;

	logic              out_v_q;
	elcsr_pkg::item_t  out_q, out_n;

	logic          acc, self_loop, oor, full, keep, drop;
	logic [VW-1:0] src, tgt;
	logic          ofree, out_ld, t_adv, row_done, finish;
	logic          fsm_we, ram_we, ram_re;
	logic [AW-1:0] fsm_waddr, ram_waddr, ram_raddr;
	logic [CW-1:0] ram_wdata, ram_rdata, base;

	assign src       = edges.data.source[VW-1:0];
	assign tgt       = edges.data.target[VW-1:0];
	assign edges.ready = (state_q == elcsr_pkg::ST_LOAD);
	assign acc       = edges.valid && edges.ready;
	assign self_loop = (edges.data.source == edges.data.target);
	assign oor       = (|edges.data.source[31:VW]) || (|edges.data.target[31:VW]);
	assign full      = (ecnt_q == CW'(elcsr_pkg::MaxEdges));
	assign keep      = acc && !self_loop && !oor && !full;
	assign drop      = acc && !self_loop && (oor || full);

	assign ofree = !out_v_q || items.ready;

	// previous write may still be in flight for the same pair
	assign base = (lw_v_q && (lw_addr_q == addr_s1)) ? lw_data_q : ram_rdata;

	assign ram_we    = v_s1 || fsm_we;
	assign ram_waddr = v_s1 ? addr_s1 : fsm_waddr;
	assign ram_wdata = v_s1 ? CW'(base + CW'(1)) : '0;

	elcsr_ram #(
		.Width(CW),
		.Depth(elcsr_pkg::PairDepth)
	) u_cnt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_n   = state_q;
		fsm_we    = 1'b0;
		fsm_waddr = {v_q, t_q};
		ram_re    = keep;
		ram_raddr = {src, tgt};
		out_ld    = 1'b0;
		out_n     = out_q;
		t_adv     = 1'b0;
		row_done  = 1'b0;
		finish    = 1'b0;
		case (state_q)
			elcsr_pkg::ST_CLR: begin
				fsm_we    = 1'b1;
				fsm_waddr = clr_q;
				if (&clr_q) begin
					state_n = elcsr_pkg::ST_LOAD;
				end
			end
			elcsr_pkg::ST_LOAD: begin
				if (acc && edges.data.last) begin
					state_n = elcsr_pkg::ST_WAIT;
				end
			end
			elcsr_pkg::ST_WAIT: begin
				state_n = elcsr_pkg::ST_HDR;
			end
			elcsr_pkg::ST_HDR: begin
				if (ofree) begin
					out_ld          = 1'b1;
					out_n.kind      = elcsr_pkg::KindHeader;
					out_n.vertex    = v_q;
					out_n.degree    = deg_q[v_q];
					out_n.neighbor  = '0;
					out_n.overflow  = ovf_q;
					out_n.last_item = (rem_q == RW'(1));
					if (deg_q[v_q] == '0) begin
						row_done = 1'b1;
					end else begin
						state_n = elcsr_pkg::ST_RD;
					end
				end
			end
			elcsr_pkg::ST_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {v_q, t_q};
				state_n   = elcsr_pkg::ST_LAT;
			end
			elcsr_pkg::ST_LAT: begin
				// zero the count as it is consumed
				fsm_we = 1'b1;
				if (ram_rdata == '0) begin
					t_adv = 1'b1;
				end else begin
					state_n = elcsr_pkg::ST_EM;
				end
			end
			elcsr_pkg::ST_EM: begin
				if (ofree) begin
					out_ld          = 1'b1;
					out_n.kind      = elcsr_pkg::KindNeighbor;
					out_n.vertex    = v_q;
					out_n.degree    = '0;
					out_n.neighbor  = t_q;
					out_n.overflow  = ovf_q;
					out_n.last_item = (rem_q == RW'(1));
					if (cnt_q == CW'(1)) begin
						// final word of the run closes the walk
						if (rem_q == RW'(1)) begin
							row_done = 1'b1;
						end else begin
							t_adv = 1'b1;
						end
					end
				end
			end
			default: begin
				state_n = elcsr_pkg::ST_LOAD;
			end
		endcase
		if (t_adv) begin
			if (&t_q) begin
				row_done = 1'b1;
			end else begin
				state_n = elcsr_pkg::ST_RD;
			end
		end
		if (row_done) begin
			if (v_q == max_q) begin
				state_n = elcsr_pkg::ST_LOAD;
				finish  = 1'b1;
			end else begin
				state_n = elcsr_pkg::ST_HDR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= elcsr_pkg::ST_CLR;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			v_q     <= '0;
			t_q     <= '0;
			cnt_q   <= '0;
			rem_q   <= '0;
			max_q   <= '0;
			ecnt_q  <= '0;
			ovf_q   <= 1'b0;
			v_s1    <= 1'b0;
			lw_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < elcsr_pkg::MaxVertices; i++) begin
				deg_q[i] <= '0;
			end
		end else begin
			if (state_q == elcsr_pkg::ST_CLR) begin
				clr_q <= AW'(clr_q + AW'(1));
			end
			v_s1   <= keep;
			lw_v_q <= v_s1;
			if (keep) begin
				deg_q[src] <= CW'(deg_q[src] + CW'(1));
				ecnt_q     <= CW'(ecnt_q + CW'(1));
				if (src > max_q && src >= tgt) begin
					max_q <= src;
				end else if (tgt > max_q) begin
					max_q <= tgt;
				end
			end
			if (drop) begin
				ovf_q <= 1'b1;
			end
			if (state_q == elcsr_pkg::ST_WAIT) begin
				rem_q <= RW'({1'b0, max_q} + RW'(1) + RW'(ecnt_q));
				v_q   <= '0;
				t_q   <= '0;
			end
			if (state_q == elcsr_pkg::ST_LAT) begin
				cnt_q <= ram_rdata;
			end else if (out_ld && state_q == elcsr_pkg::ST_EM) begin
				cnt_q <= CW'(cnt_q - CW'(1));
			end
			if (row_done) begin
				t_q <= '0;
				if (finish) begin
					v_q <= '0;
				end else begin
					v_q <= VW'(v_q + VW'(1));
				end
			end else if (t_adv) begin
				t_q <= VW'(t_q + VW'(1));
			end
			if (out_ld) begin
				rem_q   <= RW'(rem_q - RW'(1));
				out_v_q <= 1'b1;
			end else if (items.ready) begin
				out_v_q <= 1'b0;
			end
			if (finish) begin
				max_q  <= '0;
				ecnt_q <= '0;
				ovf_q  <= 1'b0;
				for (int i = 0; i < elcsr_pkg::MaxVertices; i++) begin
					deg_q[i] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= {src, tgt};
		lw_addr_q <= addr_s1;
		lw_data_q <= ram_wdata;
		if (out_ld) begin
			out_q <= out_n;
		end
	end

	assign items.valid = out_v_q;
	assign items.data  = out_q;

	// edges are only taken while loading
	a_acc_load: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> state_q == elcsr_pkg::ST_LOAD)
		else $error("edge accepted outside load phase");

	// count pipe never writes during the row walk
	a_pipe_phase: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == elcsr_pkg::ST_LOAD || state_q == elcsr_pkg::ST_WAIT))
		else $error("count write overlaps row walk");

	// never emit more words than the run holds
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |-> rem_q != '0)
		else $error("result word beyond run length");

	// the final word of a run ends the walk
	a_last_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ld && rem_q == RW'(1)) |=> state_q == elcsr_pkg::ST_LOAD)
		else $error("walk continues after final word");

endmodule

`default_nettype wire
